FILE: hdl/cossim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity package
// Shared widths, sequencer states and the command bundle that runs the
// datapath.
// ----------------------------------------------------------------------------
package cossim_pkg;

  localparam int ELEM_W    = 16;          // element width
  localparam int SIM_W     = 16;          // Q1.15 result width
  localparam int QUO_W     = 31;          // quotient of dot^2 * 2^30 / norm product
  localparam int DIV_STEPS = QUO_W - 1;   // the top quotient bit is set at load
  localparam int ROOT_W    = 16;          // integer root of the quotient

  localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};

  // Width of a sum of squares that can hold max_len full-scale squares.
  function automatic int sq_width(input int max_len);
    return 2 * ELEM_W - 1 + $clog2(max_len);
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_DOT,
    ST_MUL_DOT,
    ST_LD_NRM,
    ST_MUL_NRM,
    ST_DIV_LD,
    ST_DIV,
    ST_SQ_LD,
    ST_SQRT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accum;
    logic mul_load_dot;
    logic mul_load_nrm;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic finish;
  } dp_cmd_t;

endpackage

FILE: hdl/cosine_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity
// Streams element pairs of two vectors and reports their cosine similarity
// as Q1.15 on the final pair.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------
//  element   start, busy          elem_a, elem_b, last_elem
//  result    done (strobe)        similarity, zero_norm, overflow
//
//  An element beat is taken on every cycle with start high and busy low.
//  Beats without last_elem keep busy low. The final beat holds busy high
//  through two bit-serial multiplies, a 30-step divider and a 16-step
//  root. done pulses in the same cycle that busy falls, and a new beat may
//  be taken in that same cycle. Reset clears the sums; done is never held.
//
module cosine_similarity import cossim_pkg::*; #(
  parameter int MAX_LEN = 512
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  input  logic                     last_elem,
  output logic                     done,
  output logic signed [SIM_W-1:0]  similarity,
  output logic                     zero_norm,
  output logic                     overflow
);

  dp_cmd_t          cmd;
  logic [SIM_W-1:0] sim_c;
  logic             zero_norm_c;
  logic             overflow_c;

  cossim_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_elem (last_elem),
    .busy      (busy),
    .cmd       (cmd)
  );

  cossim_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .elem_a    (elem_a),
    .elem_b    (elem_b),
    .sim       (sim_c),
    .zero_norm (zero_norm_c),
    .overflow  (overflow_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      similarity <= $signed(sim_c);
      zero_norm  <= zero_norm_c;
      overflow   <= overflow_c;
    end
  end

endmodule

FILE: hdl/cossim_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity controller
// Takes element beats and, on the final one, steps the datapath through the
// two serial multiplies, the division and the square root.
// ----------------------------------------------------------------------------
module cossim_ctrl import cossim_pkg::*; #(
  parameter int MAX_LEN = 512
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last_elem,
  output logic    busy,
  output dp_cmd_t cmd
);

  localparam int SQ_W     = sq_width(MAX_LEN);
  localparam int MAXSTEP0 = (SQ_W > DIV_STEPS) ? SQ_W : DIV_STEPS;
  localparam int MAXSTEP  = (MAXSTEP0 > ROOT_W) ? MAXSTEP0 : ROOT_W;
  localparam int STEP_W   = $clog2(MAXSTEP);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    busy          = 1'b1;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.accum = start;
        if (start && last_elem) begin
          state_next = ST_LD_DOT;
        end
      end
      ST_LD_DOT: begin
        cmd.mul_load_dot = 1'b1;
        step_cnt_next    = STEP_W'(SQ_W - 1);
        state_next       = ST_MUL_DOT;
      end
      ST_MUL_DOT: begin
        cmd.mul_step  = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_LD_NRM;
        end
      end
      ST_LD_NRM: begin
        cmd.mul_load_nrm = 1'b1;
        step_cnt_next    = STEP_W'(SQ_W - 1);
        state_next       = ST_MUL_NRM;
      end
      ST_MUL_NRM: begin
        cmd.mul_step  = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_DIV_LD;
        end
      end
      ST_DIV_LD: begin
        cmd.div_load  = 1'b1;
        step_cnt_next = STEP_W'(DIV_STEPS - 1);
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_SQ_LD;
        end
      end
      ST_SQ_LD: begin
        cmd.sqrt_load = 1'b1;
        step_cnt_next = STEP_W'(ROOT_W - 1);
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/cossim_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity datapath
// Accumulators for the dot product and both square sums, a shared
// shift-add multiplier, a restoring divider and a bit-by-bit square root.
// ----------------------------------------------------------------------------
module cossim_dp import cossim_pkg::*; #(
  parameter int MAX_LEN = 512
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  output logic        [SIM_W-1:0]  sim,
  output logic                     zero_norm,
  output logic                     overflow
);

  localparam int SQ_W  = sq_width(MAX_LEN);
  localparam int DOT_W = SQ_W + 1;
  localparam int PW    = 2 * SQ_W;
  localparam int CNT_W = $clog2(MAX_LEN + 2);

  logic signed [DOT_W-1:0]    dot_sum;
  logic        [SQ_W-1:0]     square_sum_a;
  logic        [SQ_W-1:0]     square_sum_b;
  logic        [CNT_W-1:0]    element_count;

  logic signed [2*ELEM_W-1:0] prod_ab, prod_aa, prod_bb;
  logic                       dot_neg;
  logic        [DOT_W-1:0]    dot_abs;

  logic        [SQ_W-1:0]     mcand, mop;
  logic        [PW-1:0]       macc, dot2;
  logic        [PW-1:0]       rem;
  logic        [PW:0]         rem2;
  logic        [QUO_W-1:0]    quo;
  logic        [ROOT_W-1:0]   root, bitm, trial;
  logic        [2*ROOT_W-1:0] trial_sq;

  assign prod_ab = elem_a * elem_b;
  assign prod_aa = elem_a * elem_a;
  assign prod_bb = elem_b * elem_b;

  // Pairs beyond MAX_LEN are dropped and the count parks one above it.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      dot_sum       <= '0;
      square_sum_a  <= '0;
      square_sum_b  <= '0;
      element_count <= '0;
    end else if (cmd.accum) begin
      if (element_count < CNT_W'(MAX_LEN)) begin
        dot_sum       <= dot_sum + DOT_W'(prod_ab);
        square_sum_a  <= square_sum_a + SQ_W'($unsigned(prod_aa));
        square_sum_b  <= square_sum_b + SQ_W'($unsigned(prod_bb));
        element_count <= element_count + 1'b1;
      end else begin
        element_count <= CNT_W'(MAX_LEN + 1);
      end
    end
  end

  assign dot_neg = dot_sum[DOT_W-1];
  assign dot_abs = dot_neg ? $unsigned(-dot_sum) : $unsigned(dot_sum);

  // MSB-first shift-add multiplier; the product of the norms stays in macc
  // and serves as the divisor afterwards.
  always_ff @(posedge clk) begin
    if (cmd.mul_load_dot) begin
      mcand <= dot_abs[SQ_W-1:0];
      mop   <= dot_abs[SQ_W-1:0];
      macc  <= '0;
    end else if (cmd.mul_load_nrm) begin
      dot2  <= macc;
      mcand <= square_sum_a;
      mop   <= square_sum_b;
      macc  <= '0;
    end else if (cmd.mul_step) begin
      macc <= {macc[PW-2:0], 1'b0} + (mop[SQ_W-1] ? PW'(mcand) : '0);
      mop  <= {mop[SQ_W-2:0], 1'b0};
    end
  end

  // Restoring division of dot^2 * 2^30 by the norm product. Since the
  // quotient never exceeds 2^30, its top bit is settled at load.
  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      if (dot2 >= macc) begin
        rem <= dot2 - macc;
        quo <= QUO_W'(1);
      end else begin
        rem <= dot2;
        quo <= '0;
      end
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, macc}) begin
        rem <= PW'(rem2 - {1'b0, macc});
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem2[PW-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Integer square root, one result bit per cycle from the top.
  assign trial    = root | bitm;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      root <= '0;
      bitm <= {1'b1, {(ROOT_W-1){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (trial_sq <= (2*ROOT_W)'(quo)) begin
        root <= trial;
      end
      bitm <= {1'b0, bitm[ROOT_W-1:1]};
    end
  end

  assign zero_norm = (square_sum_a == '0) || (square_sum_b == '0);
  assign overflow  = element_count > CNT_W'(MAX_LEN);

  // Exactly minus one survives as the most negative code; plus one saturates.
  always_comb begin
    if (zero_norm) begin
      sim = '0;
    end else if (dot_neg) begin
      sim = SIM_W'('0 - root);
    end else if (root[ROOT_W-1]) begin
      sim = SIM_MAX;
    end else begin
      sim = SIM_W'(root);
    end
  end

endmodule

FILE: hdl/cossim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity checker
// Port-level checks on the element and result channels, bound to the top.
// ----------------------------------------------------------------------------
module cossim_assertions import cossim_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     last_elem,
  input logic                     done,
  input logic signed [SIM_W-1:0]  similarity,
  input logic                     zero_norm
);

  // A result only ever follows a stretch of busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding busy period");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    (done && zero_norm) |-> (similarity == '0))
    else $error("zero norm result with non-zero similarity");

  a_mid_beat_no_stall: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_elem) |=> !busy)
    else $error("busy raised after a beat that was not the last");

  a_last_beat_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_elem) |=> busy)
    else $error("busy not raised after the final beat");

endmodule

bind cosine_similarity cossim_assertions u_cossim_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .last_elem  (last_elem),
  .done       (done),
  .similarity (similarity),
  .zero_norm  (zero_norm)
);
